// ===== hw/rtl/qrs_pkg.sv =====
// Shared types and constants for the quadratic root solver.
`default_nettype none
package qrs_pkg;

  typedef enum logic [1:0] {
    CLS_NONE     = 2'd0,
    CLS_ONE      = 2'd1,
    CLS_TWO      = 2'd2,
    CLS_INFINITE = 2'd3
  } root_class_e;

  // Case decided by the front end.
  typedef enum logic [2:0] {
    KIND_ZERO   = 3'b001,  // no roots or infinitely many, roots forced to zero
    KIND_LINEAR = 3'b010,  // one root -c/b
    KIND_QUAD   = 3'b100   // roots from discriminant
  } kind_e;

endpackage
`default_nettype wire

// ===== hw/rtl/quadratic_root_solver.sv =====
// Top level of the quadratic root solver.
`default_nettype none
// Solves a*x^2+b*x+c=0 for signed fixed-point coefficients, one triple per
// cycle. The front end takes magnitudes, forms b*b-4ac exactly and classifies
// the triple; the back end runs a one-bit-per-stage square root and two
// one-bit-per-stage dividers. The whole pipe advances together; a small
// output queue takes the words in flight when the sink stalls, and
// s_axis_tready drops only when that queue could not hold everything still
// in the pipe.
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int unsigned COEF_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // coef_a, coef_b, coef_c from bit 0 up
  input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // root_class, root_first, root_second, saturated from bit 0 up
  output logic [((2*COEF_WIDTH+3+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned CW = COEF_WIDTH;
  localparam int unsigned OW = 2 * CW + 3;
  localparam int unsigned OPAD = ((OW + 7) / 8) * 8;
  localparam int unsigned LAT = 3 + (CW + 1) + 1 + (CW + 2 + FRAC_BITS);
  localparam int unsigned DEPTH = LAT + 2;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  // The pipe always advances; the queue reserves room for all in flight.
  logic           en;
  logic           acc;
  logic [CNTW-1:0] q_cnt;
  logic [$clog2(LAT+2)-1:0] fly_q;
  logic           out_v;
  logic           pop;

  assign en  = 1'b1;
  assign s_axis_tready = ({1'b0, q_cnt} + (CNTW+1)'(fly_q)) < (CNTW+1)'(DEPTH);
  assign acc = s_axis_tvalid & s_axis_tready;

  kind_e           f_kind;
  root_class_e     f_cls;
  logic [2*CW+1:0] f_disc;
  logic            f_v, f_dz, f_na, f_nb, f_nc;
  logic [CW-1:0]   f_ma, f_mb, f_mc;

  qrs_front #(.CW(CW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (acc),
    .a_i     (s_axis_tdata[CW-1:0]),
    .b_i     (s_axis_tdata[2*CW-1:CW]),
    .c_i     (s_axis_tdata[3*CW-1:2*CW]),
    .valid_o (f_v),
    .kind_o  (f_kind),
    .cls_o   (f_cls),
    .disc_o  (f_disc),
    .dzero_o (f_dz),
    .na_o    (f_na),
    .nb_o    (f_nb),
    .nc_o    (f_nc),
    .ma_o    (f_ma),
    .mb_o    (f_mb),
    .mc_o    (f_mc)
  );

  logic [1:0]    b_cls;
  logic [CW-1:0] b_r1, b_r2;
  logic          b_sat;

  qrs_back #(.CW(CW), .FB(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_v),
    .kind_i  (f_kind),
    .cls_i   (f_cls),
    .disc_i  (f_disc),
    .dzero_i (f_dz),
    .na_i    (f_na),
    .nb_i    (f_nb),
    .nc_i    (f_nc),
    .ma_i    (f_ma),
    .mb_i    (f_mb),
    .mc_i    (f_mc),
    .valid_o (out_v),
    .cls_o   (b_cls),
    .r1_o    (b_r1),
    .r2_o    (b_r2),
    .sat_o   (b_sat)
  );

  // words in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fly_q <= '0;
    end else begin
      fly_q <= fly_q + $bits(fly_q)'(acc) - $bits(fly_q)'(out_v);
    end
  end

  logic          q_v;
  logic [OW-1:0] q_data;

  qrs_fifo #(.W(OW), .DEPTH(DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_v),
    .data_i  ({b_sat, b_r2, b_r1, b_cls}),
    .pop_i   (pop),
    .valid_o (q_v),
    .data_o  (q_data),
    .count_o (q_cnt)
  );

  assign pop           = q_v & m_axis_tready;
  assign m_axis_tvalid = q_v;
  assign m_axis_tdata  = OPAD'(q_data);

endmodule
`default_nettype wire

// ===== hw/rtl/qrs_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module qrs_isqrt
  import qrs_pkg::*;
#(
  parameter int unsigned RW = 32,
  parameter int unsigned TW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [2*RW-1:0] rad_i,
  input  wire logic [TW-1:0]   tag_i,
  output logic                 valid_o,
  output logic [RW-1:0]        root_o,
  output logic [TW-1:0]        tag_o
);

  // Restoring square root: remainder carried with root, radicand shifted up.
  logic [RW:0]     vld_q;
  logic [2*RW-1:0] rad_q [RW+1];
  logic [RW+1:0]   rem_q [RW+1];
  logic [RW-1:0]   rt_q  [RW+1];
  logic [TW-1:0]   tag_q [RW+1];

  always_comb begin
    rad_q[0] = rad_i;
    rem_q[0] = '0;
    rt_q[0]  = '0;
    tag_q[0] = tag_i;
    vld_q[0] = valid_i;
  end

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          ok;
    always_comb begin
      rem_sh = {rem_q[s][RW-1:0], rad_q[s][2*RW-1:2*RW-2]};
      trial  = {rt_q[s], 2'b01};
      ok     = rem_sh >= trial;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s+1] <= {rad_q[s][2*RW-3:0], 2'b00};
        rem_q[s+1] <= ok ? rem_sh - trial : rem_sh;
        rt_q[s+1]  <= {rt_q[s][RW-2:0], ok};
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign valid_o = vld_q[RW];
  assign root_o  = rt_q[RW];
  assign tag_o   = tag_q[RW];

endmodule
`default_nettype wire

// ===== hw/rtl/qrs_div.sv =====
// Pipelined unsigned restoring divider with saturating signed result.
`default_nettype none
module qrs_div
  import qrs_pkg::*;
#(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 33,
  parameter int unsigned OW = 32,
  parameter int unsigned TW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic          neg_i,
  input  wire logic [TW-1:0] tag_i,
  output logic               valid_o,
  output logic [OW-1:0]      quo_o,
  output logic               sat_o,
  output logic [TW-1:0]      tag_o
);

  logic [NW:0]     vld_q;
  logic [NW-1:0]   num_q [NW+1];
  logic [DW:0]     rem_q [NW+1];
  logic [DW-1:0]   den_q [NW+1];
  logic            big_q [NW+1];   // quotient exceeds NW-bit window is impossible; tracks overflow
  logic            neg_q [NW+1];
  logic [TW-1:0]   tag_q [NW+1];
  logic [OW:0]     quo_q [NW+1];   // low OW+1 quotient bits

  always_comb begin
    vld_q[0] = valid_i;
    num_q[0] = num_i;
    rem_q[0] = '0;
    den_q[0] = den_i;
    big_q[0] = 1'b0;
    neg_q[0] = neg_i;
    tag_q[0] = tag_i;
    quo_q[0] = '0;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] rem_sh;
    logic        ok;
    always_comb begin
      rem_sh = {rem_q[s][DW-1:0], num_q[s][NW-1]};
      ok     = rem_sh >= {1'b0, den_q[s]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= {num_q[s][NW-2:0], 1'b0};
        rem_q[s+1] <= ok ? rem_sh - {1'b0, den_q[s]} : rem_sh;
        den_q[s+1] <= den_q[s];
        big_q[s+1] <= big_q[s] | quo_q[s][OW];
        neg_q[s+1] <= neg_q[s];
        tag_q[s+1] <= tag_q[s];
        quo_q[s+1] <= {quo_q[s][OW-1:0], ok};
      end
    end
  end

  localparam logic [OW:0] LimPos = {2'b00, {(OW-1){1'b1}}};
  localparam logic [OW:0] LimNeg = {2'b01, {(OW-1){1'b0}}};

  logic          over;
  logic [OW-1:0] mag;
  always_comb begin
    if (neg_q[NW]) begin
      over = big_q[NW] || (quo_q[NW] > LimNeg);
      mag  = over ? LimNeg[OW-1:0] : quo_q[NW][OW-1:0];
      quo_o = OW'(~mag + 1'b1);
    end else begin
      over = big_q[NW] || (quo_q[NW] > LimPos);
      mag  = over ? LimPos[OW-1:0] : quo_q[NW][OW-1:0];
      quo_o = mag;
    end
  end

  assign valid_o = vld_q[NW];
  assign sat_o   = over;
  assign tag_o   = tag_q[NW];

endmodule
`default_nettype wire

// ===== hw/rtl/qrs_front.sv =====
// Front end: splits signs, forms the discriminant and classifies the triple.
`default_nettype none
module qrs_front
  import qrs_pkg::*;
#(
  parameter int unsigned CW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [CW-1:0] a_i,
  input  wire logic [CW-1:0] b_i,
  input  wire logic [CW-1:0] c_i,
  output logic               valid_o,
  output kind_e              kind_o,
  output root_class_e        cls_o,
  output logic [2*CW+1:0]    disc_o,
  output logic               dzero_o,
  output logic               na_o,
  output logic               nb_o,
  output logic               nc_o,
  output logic [CW-1:0]      ma_o,
  output logic [CW-1:0]      mb_o,
  output logic [CW-1:0]      mc_o
);

  // stage 1: magnitudes
  logic          v1_q;
  logic          na_q, nb_q, nc_q;
  logic [CW-1:0] ma_q, mb_q, mc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_q <= a_i[CW-1];
      nb_q <= b_i[CW-1];
      nc_q <= c_i[CW-1];
      ma_q <= a_i[CW-1] ? CW'(-a_i) : a_i;
      mb_q <= b_i[CW-1] ? CW'(-b_i) : b_i;
      mc_q <= c_i[CW-1] ? CW'(-c_i) : c_i;
    end
  end

  // stage 2: products
  logic            v2_q;
  logic            na2_q, nb2_q, nc2_q;
  logic [CW-1:0]   ma2_q, mb2_q, mc2_q;
  logic [2*CW-1:0] bsq_q, ac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na2_q <= na_q;
      nb2_q <= nb_q;
      nc2_q <= nc_q;
      ma2_q <= ma_q;
      mb2_q <= mb_q;
      mc2_q <= mc_q;
      bsq_q <= mb_q * mb_q;
      ac_q  <= ma_q * mc_q;
    end
  end

  // stage 3: discriminant and class
  logic [2*CW+1:0] bsq_w, fac_w, sum_w, dif_w, disc_d;
  logic            dneg;
  kind_e           kind_d;
  root_class_e     cls_d;

  always_comb begin
    bsq_w  = {2'b00, bsq_q};
    fac_w  = {ac_q, 2'b00};
    sum_w  = bsq_w + fac_w;
    dif_w  = bsq_w - fac_w;
    dneg   = (na2_q == nc2_q) && (bsq_w < fac_w);
    disc_d = (na2_q != nc2_q) ? sum_w : (dneg ? '0 : dif_w);
    if (ma2_q == '0) begin
      if (mb2_q == '0) begin
        kind_d = KIND_ZERO;
        cls_d  = (mc2_q == '0) ? CLS_INFINITE : CLS_NONE;
      end else begin
        kind_d = KIND_LINEAR;
        cls_d  = CLS_ONE;
      end
    end else if (dneg) begin
      kind_d = KIND_ZERO;
      cls_d  = CLS_NONE;
    end else begin
      kind_d = KIND_QUAD;
      cls_d  = (disc_d == '0) ? CLS_ONE : CLS_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_o  <= kind_d;
      cls_o   <= cls_d;
      disc_o  <= disc_d;
      dzero_o <= (disc_d == '0);
      na_o    <= na2_q;
      nb_o    <= nb2_q;
      nc_o    <= nc2_q;
      ma_o    <= ma2_q;
      mb_o    <= mb2_q;
      mc_o    <= mc2_q;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qrs_back.sv =====
// Back end: square root, numerators, the two dividers and result assembly.
`default_nettype none
module qrs_back
  import qrs_pkg::*;
#(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  kind_e              kind_i,
  input  root_class_e        cls_i,
  input  wire logic [2*CW+1:0] disc_i,
  input  wire logic          dzero_i,
  input  wire logic          na_i,
  input  wire logic          nb_i,
  input  wire logic          nc_i,
  input  wire logic [CW-1:0] ma_i,
  input  wire logic [CW-1:0] mb_i,
  input  wire logic [CW-1:0] mc_i,
  output logic               valid_o,
  output logic [1:0]         cls_o,
  output logic [CW-1:0]      r1_o,
  output logic [CW-1:0]      r2_o,
  output logic               sat_o
);

  localparam int unsigned RW = CW + 1;        // sqrt width
  localparam int unsigned NMW = CW + 2;       // numerator magnitude width
  localparam int unsigned NW = NMW + FB;      // shifted numerator width
  localparam int unsigned DW = CW + 1;        // denominator width
  // side info through the sqrt: kind, class, signs, magnitudes
  localparam int unsigned TW = 3 + 2 + 4 + 3 * CW;

  logic [TW-1:0] tag_in, tag_sq;
  logic          vld_sq;
  logic [RW-1:0] s_root;

  assign tag_in = {kind_i, cls_i, dzero_i, na_i, nb_i, nc_i, ma_i, mb_i, mc_i};

  // disc < 2^(2CW+1); fits a 2*RW-bit radicand
  qrs_isqrt #(.RW(RW), .TW(TW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_i),
    .rad_i   ((2*RW)'(disc_i)),
    .tag_i   (tag_in),
    .valid_o (vld_sq),
    .root_o  (s_root),
    .tag_o   (tag_sq)
  );

  logic [$bits(kind_e)-1:0] k_s;
  logic [1:0]    c_s;
  logic          dz_s, na_s, nb_s, nc_s;
  logic [CW-1:0] ma_s, mb_s, mc_s;
  assign {k_s, c_s, dz_s, na_s, nb_s, nc_s, ma_s, mb_s, mc_s} = tag_sq;

  // numerators: n = -b +/- s, signed NMW+1 bits
  logic signed [NMW:0] bv, n1, n2;
  logic [NMW-1:0]      m1, m2;
  logic                s1, s2;
  logic [NMW-1:0]      num1, num2;
  logic [DW-1:0]       den;
  logic                neg1, neg2;

  always_comb begin
    bv = nb_s ? -$signed({3'b000, mb_s}) : $signed({3'b000, mb_s});
    n1 = -bv + $signed({2'b00, s_root});
    n2 = -bv - $signed({2'b00, s_root});
    m1 = n1[NMW] ? NMW'(-n1) : NMW'(n1);
    m2 = n2[NMW] ? NMW'(-n2) : NMW'(n2);
    s1 = n1[NMW];
    s2 = n2[NMW];
    case (k_s)
      KIND_LINEAR: begin
        num1 = NMW'(mc_s);
        num2 = NMW'(mc_s);
        den  = DW'(mb_s);
        neg1 = (nc_s == nb_s);
        neg2 = neg1;
      end
      KIND_QUAD: begin
        den = {ma_s, 1'b0};
        if (dz_s) begin
          num1 = NMW'(mb_s);
          num2 = NMW'(mb_s);
          neg1 = (nb_s == na_s);
          neg2 = neg1;
        end else begin
          num1 = m1;
          num2 = m2;
          neg1 = s1 != na_s;
          neg2 = s2 != na_s;
        end
      end
      default: begin
        num1 = '0;
        num2 = '0;
        den  = DW'(1);
        neg1 = 1'b0;
        neg2 = 1'b0;
      end
    endcase
  end

  // register numerators before the dividers
  logic            vn_q;
  logic [NMW-1:0]  num1_q, num2_q;
  logic [DW-1:0]   den_q;
  logic            neg1_q, neg2_q, zero_q;
  logic [1:0]      cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (en_i) begin
      vn_q <= vld_sq;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num1_q <= num1;
      num2_q <= num2;
      den_q  <= den;
      neg1_q <= neg1;
      neg2_q <= neg2;
      zero_q <= (k_s == KIND_ZERO);
      cls_q  <= c_s;
    end
  end

  localparam int unsigned STW = 3;
  logic          vd1, vd2;
  logic [CW-1:0] q1, q2;
  logic          st1, st2;
  logic [STW-1:0] t1, t2;

  qrs_div #(.NW(NW), .DW(DW), .OW(CW), .TW(STW)) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vn_q),
    .num_i   ({num1_q, {FB{1'b0}}}),
    .den_i   (den_q),
    .neg_i   (neg1_q),
    .tag_i   ({zero_q, cls_q}),
    .valid_o (vd1),
    .quo_o   (q1),
    .sat_o   (st1),
    .tag_o   (t1)
  );

  qrs_div #(.NW(NW), .DW(DW), .OW(CW), .TW(STW)) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vn_q),
    .num_i   ({num2_q, {FB{1'b0}}}),
    .den_i   (den_q),
    .neg_i   (neg2_q),
    .tag_i   ({zero_q, cls_q}),
    .valid_o (vd2),
    .quo_o   (q2),
    .sat_o   (st2),
    .tag_o   (t2)
  );

  always_comb begin
    valid_o = vd1 & vd2;
    cls_o   = t1[1:0];
    if (t1[2]) begin
      r1_o  = '0;
      r2_o  = '0;
      sat_o = 1'b0;
    end else begin
      r1_o  = q1;
      r2_o  = q2;
      sat_o = st1 | st2;
    end
  end

  logic unused_t2;
  assign unused_t2 = ^t2;

endmodule
`default_nettype wire

// ===== hw/rtl/qrs_fifo.sv =====
// Small output queue that absorbs words still in the pipeline on a stall.
`default_nettype none
module qrs_fifo
  import qrs_pkg::*;
#(
  parameter int unsigned W = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic [W-1:0]      data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [AW-1:0]   wp_q, rp_q;
  logic [CNTW-1:0] cnt_q;     // words held in the array
  logic            out_v_q;
  logic [W-1:0]    out_q;     // head word, registered from the array
  logic            load, rd, wr;

  // With the array empty, a push loads a free or popping head register.
  always_comb begin
    load = !out_v_q || pop_i;
    rd   = load && (cnt_q != '0);
    wr   = push_i && !(load && (cnt_q == '0));
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd) begin
      out_q <= mem_q[rp_q];
    end else if (load && push_i) begin
      out_q <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (wr) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (rd) begin
        rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + CNTW'(wr) - CNTW'(rd);
      if (load) begin
        out_v_q <= rd | push_i;
      end
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;
  assign count_o = cnt_q + CNTW'(out_v_q);

endmodule
`default_nettype wire
